// ----- hw/rtl/mfbf_pkg.sv -----
package mfbf_pkg;

    localparam int DEFAULT_MAX_NODE_COUNT = 64;
    localparam int NODE_COUNT_RESET = 64;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    localparam logic [22:0] TOTAL_MAX = 23'd4194303;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  from_node;
        logic [5:0]  to_node;
        logic [15:0] edge_capacity;
        logic [5:0]  source_node;
        logic [5:0]  sink_node;
    } cmd_t;

    typedef struct packed {
        logic [21:0] total_flow;
        logic        same_node_error;
    } result_t;

endpackage

// ----- hw/rtl/mfbf_ram.sv -----
module mfbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/max_flow_breadth_first.sv -----
// Maximum-flow engine using breadth-first augmenting paths. A transaction is taken when
// start is high and busy is low. A write transaction stores one edge capacity; a clear
// transaction sweeps the capacity memory. A run transaction with a valid source and
// sink first sweeps the flow memory; then each search examines the unvisited neighbours
// of every node popped, and each augmenting path is walked twice, for its bottleneck and
// to update flows, as all matrix accesses share one read port of each memory. The result
// appears on result for exactly one cycle with done high and must be captured then,
// since the receiver cannot stall the block.
module max_flow_breadth_first #(
    parameter int MAX_NODE_COUNT = mfbf_pkg::DEFAULT_MAX_NODE_COUNT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mfbf_pkg::cmd_t   cmd,
    output logic             done,
    output mfbf_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [6:0]       cfg_wdata
);

    localparam int NW    = (MAX_NODE_COUNT > 1) ? $clog2(MAX_NODE_COUNT) : 1;
    localparam int DEPTH = MAX_NODE_COUNT * MAX_NODE_COUNT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_CAPCLR  = 5'd1;
    localparam logic [4:0] S_FLOWCLR = 5'd2;
    localparam logic [4:0] S_BFSINIT = 5'd3;
    localparam logic [4:0] S_POP     = 5'd4;
    localparam logic [4:0] S_POPW    = 5'd5;
    localparam logic [4:0] S_SCAN    = 5'd6;
    localparam logic [4:0] S_CHK     = 5'd7;
    localparam logic [4:0] S_W1TEST  = 5'd8;
    localparam logic [4:0] S_W1PW    = 5'd9;
    localparam logic [4:0] S_W1RD    = 5'd10;
    localparam logic [4:0] S_W1CMP   = 5'd11;
    localparam logic [4:0] S_W2TEST  = 5'd12;
    localparam logic [4:0] S_W2PW    = 5'd13;
    localparam logic [4:0] S_W2RF    = 5'd14;
    localparam logic [4:0] S_W2WF    = 5'd15;
    localparam logic [4:0] S_W2RR    = 5'd16;
    localparam logic [4:0] S_W2WR    = 5'd17;
    localparam logic [4:0] S_FINISH  = 5'd18;

    function automatic logic [AW-1:0] mat_addr(input logic [NW-1:0] a, input logic [NW-1:0] b);
        mat_addr = AW'(AW'(a) * AW'(MAX_NODE_COUNT) + AW'(b));
    endfunction

    logic [4:0]              state_reg, state_next;
    logic [6:0]              node_count_reg;
    logic [NW:0]             n_reg, n_next;
    logic [NW-1:0]           src_reg, src_next, snk_reg, snk_next;
    logic [NW-1:0]           u_reg, u_next, x_reg, x_next, p_reg, p_next;
    logic [NW:0]             v_reg, v_next, head_reg, head_next, tail_reg, tail_next;
    logic [MAX_NODE_COUNT-1:0] visited_reg, visited_next;
    logic [17:0]             inc_reg, inc_next;
    logic                    first_reg, first_next;
    logic [22:0]             total_reg, total_next;
    logic [AW-1:0]           clr_reg, clr_next;
    logic                    done_reg, done_next;
    mfbf_pkg::result_t       result_reg, result_next;

    logic              cap_we, flow_we, q_we, pred_we;
    logic [AW-1:0]     cap_waddr, flow_waddr, mat_raddr;
    logic [15:0]       cap_wdata, cap_rdata;
    logic [16:0]       flow_wdata, flow_rdata;
    logic [NW-1:0]     q_waddr, q_wdata, q_raddr, q_rdata;
    logic [NW-1:0]     pred_waddr, pred_wdata, pred_raddr, pred_rdata;
    logic signed [18:0] res;
    logic              res_pos;
    logic              accept;
    logic [NW:0]       n_eff;

    mfbf_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_cap (
        .clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
        .raddr(mat_raddr), .rdata(cap_rdata)
    );

    mfbf_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_flow (
        .clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
        .raddr(mat_raddr), .rdata(flow_rdata)
    );

    mfbf_ram #(.WIDTH(NW), .DEPTH(MAX_NODE_COUNT)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    mfbf_ram #(.WIDTH(NW), .DEPTH(MAX_NODE_COUNT)) u_pred (
        .clk(clk), .we(pred_we), .waddr(pred_waddr), .wdata(pred_wdata),
        .raddr(pred_raddr), .rdata(pred_rdata)
    );

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && !busy;
    assign done    = done_reg;
    assign result  = result_reg;
    assign res     = $signed({3'b000, cap_rdata}) - $signed({{2{flow_rdata[16]}}, flow_rdata});
    assign res_pos = !res[18] && (res != 19'sd0);

    always_comb
    begin
        if (32'(node_count_reg) < 2)
        begin
            n_eff = (NW + 1)'(2);
        end
        else if (32'(node_count_reg) > MAX_NODE_COUNT)
        begin
            n_eff = (NW + 1)'(MAX_NODE_COUNT);
        end
        else
        begin
            n_eff = (NW + 1)'(node_count_reg);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        src_next     = src_reg;
        snk_next     = snk_reg;
        u_next       = u_reg;
        x_next       = x_reg;
        p_next       = p_reg;
        v_next       = v_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        visited_next = visited_reg;
        inc_next     = inc_reg;
        first_next   = first_reg;
        total_next   = total_reg;
        clr_next     = clr_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        cap_we       = 1'b0;
        cap_waddr    = clr_reg;
        cap_wdata    = '0;
        flow_we      = 1'b0;
        flow_waddr   = clr_reg;
        flow_wdata   = '0;
        mat_raddr    = mat_addr(u_reg, v_reg[NW-1:0]);
        q_we         = 1'b0;
        q_waddr      = tail_reg[NW-1:0];
        q_wdata      = v_reg[NW-1:0];
        q_raddr      = head_reg[NW-1:0];
        pred_we      = 1'b0;
        pred_waddr   = v_reg[NW-1:0];
        pred_wdata   = u_reg;
        pred_raddr   = x_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.opcode)
                        mfbf_pkg::OP_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = S_CAPCLR;
                        end
                        mfbf_pkg::OP_WRITE:
                        begin
                            if (32'(cmd.from_node) < MAX_NODE_COUNT
                                && 32'(cmd.to_node) < MAX_NODE_COUNT)
                            begin
                                cap_we    = 1'b1;
                                cap_waddr = mat_addr(NW'(cmd.from_node), NW'(cmd.to_node));
                                cap_wdata = cmd.edge_capacity;
                            end
                        end
                        mfbf_pkg::OP_RUN:
                        begin
                            if (cmd.source_node == cmd.sink_node)
                            begin
                                done_next   = 1'b1;
                                result_next = '{total_flow: '0, same_node_error: 1'b1};
                            end
                            else if (32'(cmd.source_node) >= 32'(n_eff)
                                     || 32'(cmd.sink_node) >= 32'(n_eff))
                            begin
                                done_next   = 1'b1;
                                result_next = '{total_flow: '0, same_node_error: 1'b0};
                            end
                            else
                            begin
                                n_next     = n_eff;
                                src_next   = NW'(cmd.source_node);
                                snk_next   = NW'(cmd.sink_node);
                                total_next = '0;
                                clr_next   = '0;
                                state_next = S_FLOWCLR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_CAPCLR:
            begin
                cap_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_FLOWCLR:
            begin
                flow_we  = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_BFSINIT;
                end
            end
            S_BFSINIT:
            begin
                visited_next          = '0;
                visited_next[src_reg] = 1'b1;
                q_we                  = 1'b1;
                q_waddr               = '0;
                q_wdata               = src_reg;
                head_next             = '0;
                tail_next             = (NW + 1)'(1);
                state_next            = S_POP;
            end
            S_POP:
            begin
                if (head_reg == tail_reg)
                begin
                    if (visited_reg[snk_reg])
                    begin
                        x_next     = snk_reg;
                        first_next = 1'b1;
                        state_next = S_W1TEST;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                u_next     = q_rdata;
                v_next     = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (v_reg == n_reg)
                begin
                    state_next = S_POP;
                end
                else if (visited_reg[v_reg[NW-1:0]])
                begin
                    v_next = v_reg + 1'b1;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (res_pos)
                begin
                    visited_next[v_reg[NW-1:0]] = 1'b1;
                    q_we      = 1'b1;
                    pred_we   = 1'b1;
                    tail_next = tail_reg + 1'b1;
                end
                v_next     = v_reg + 1'b1;
                state_next = S_SCAN;
            end
            S_W1TEST:
            begin
                if (x_reg == src_reg)
                begin
                    x_next     = snk_reg;
                    state_next = S_W2TEST;
                end
                else
                begin
                    state_next = S_W1PW;
                end
            end
            S_W1PW:
            begin
                p_next     = pred_rdata;
                state_next = S_W1RD;
            end
            S_W1RD:
            begin
                mat_raddr  = mat_addr(p_reg, x_reg);
                state_next = S_W1CMP;
            end
            S_W1CMP:
            begin
                if (first_reg || (res[17:0] < inc_reg))
                begin
                    inc_next = res[17:0];
                end
                first_next = 1'b0;
                x_next     = p_reg;
                state_next = S_W1TEST;
            end
            S_W2TEST:
            begin
                if (x_reg == src_reg)
                begin
                    total_next = total_reg + 23'(inc_reg);
                    state_next = S_BFSINIT;
                end
                else
                begin
                    state_next = S_W2PW;
                end
            end
            S_W2PW:
            begin
                p_next     = pred_rdata;
                state_next = S_W2RF;
            end
            S_W2RF:
            begin
                mat_raddr  = mat_addr(p_reg, x_reg);
                state_next = S_W2WF;
            end
            S_W2WF:
            begin
                flow_we    = 1'b1;
                flow_waddr = mat_addr(p_reg, x_reg);
                flow_wdata = flow_rdata + 17'(inc_reg);
                state_next = S_W2RR;
            end
            S_W2RR:
            begin
                mat_raddr  = mat_addr(x_reg, p_reg);
                state_next = S_W2WR;
            end
            S_W2WR:
            begin
                flow_we    = 1'b1;
                flow_waddr = mat_addr(x_reg, p_reg);
                flow_wdata = flow_rdata - 17'(inc_reg);
                x_next     = p_reg;
                state_next = S_W2TEST;
            end
            S_FINISH:
            begin
                done_next   = 1'b1;
                result_next.same_node_error = 1'b0;
                result_next.total_flow = (total_reg > mfbf_pkg::TOTAL_MAX)
                    ? 22'(mfbf_pkg::TOTAL_MAX) : total_reg[21:0];
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= 7'(mfbf_pkg::NODE_COUNT_RESET);
            done_reg       <= 1'b0;
            visited_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            total_reg      <= '0;
            clr_reg        <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            visited_reg <= visited_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            total_reg   <= total_next;
            clr_reg     <= clr_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        src_reg    <= src_next;
        snk_reg    <= snk_next;
        u_reg      <= u_next;
        x_reg      <= x_next;
        p_reg      <= p_next;
        v_reg      <= v_next;
        inc_reg    <= inc_next;
        first_reg  <= first_next;
        result_reg <= result_next;
    end

endmodule

// ----- hw/rtl/mfbf_checker.sv -----
module mfbf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input mfbf_pkg::cmd_t    cmd,
    input logic              done,
    input mfbf_pkg::result_t result
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("A result was shown while the block was busy.");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.same_node_error |-> result.total_flow == 22'd0)
        else $error("An error result carried a non-zero flow.");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.opcode == mfbf_pkg::OP_CLEAR |=> busy)
        else $error("A clear transaction did not make the block busy.");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("A result appeared without a preceding transaction.");

endmodule

bind max_flow_breadth_first mfbf_checker u_mfbf_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
);

// ----- tb/sv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES = 64;
    localparam longint CYCLE_LIMIT = 20000000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    mfbf_pkg::cmd_t cmd;
    logic done;
    mfbf_pkg::result_t result;
    logic cfg_we;
    logic [6:0] cfg_wdata;

    max_flow_breadth_first u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    mfbf_pkg::cmd_t pending_cmds[$];
    mfbf_pkg::result_t expected_results[$];
    int unsigned capacity[NODES * NODES];
    int flow[NODES * NODES];
    logic [6:0] node_count_reg;
    logic took;
    int gap_cycles;
    bit quiet_tail;
    int errors;
    longint cycles;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic int active_count();
        if (node_count_reg < 2)
        begin
            return 2;
        end
        if (node_count_reg > NODES)
        begin
            return NODES;
        end
        return node_count_reg;
    endfunction

    function automatic longint max_flow_value(int n, int src, int snk);
        int color[NODES];
        int pred[NODES];
        int order[NODES];
        int head;
        int tail;
        int u;
        int v;
        int steps;
        int inc;
        int r;
        longint total;
        total = 0;
        foreach (flow[i])
        begin
            flow[i] = 0;
        end
        for (int i = 0; i < n; i++)
        begin
            pred[i] = 0;
        end
        forever
        begin
            for (int i = 0; i < n; i++)
            begin
                color[i] = 0;
            end
            head = 0;
            tail = 1;
            order[0] = src;
            color[src] = 1;
            pred[src] = src;
            while (head != tail)
            begin
                u = order[head];
                head++;
                color[u] = 2;
                for (v = 0; v < n; v++)
                begin
                    if (color[v] == 0 && int'(capacity[u * NODES + v]) - flow[u * NODES + v] > 0)
                    begin
                        if (tail < NODES)
                        begin
                            order[tail] = v;
                            tail++;
                        end
                        color[v] = 1;
                        pred[v] = u;
                    end
                end
            end
            if (color[snk] != 2)
            begin
                break;
            end
            inc = 1000000000;
            u = snk;
            steps = 0;
            while (u != src && steps < n)
            begin
                r = int'(capacity[pred[u] * NODES + u]) - flow[pred[u] * NODES + u];
                if (r < inc)
                begin
                    inc = r;
                end
                u = pred[u];
                steps++;
            end
            if (inc <= 0)
            begin
                break;
            end
            u = snk;
            steps = 0;
            while (u != src && steps < n)
            begin
                flow[pred[u] * NODES + u] += inc;
                flow[u * NODES + pred[u]] -= inc;
                u = pred[u];
                steps++;
            end
            total += inc;
        end
        return total;
    endfunction

    function automatic void predict(mfbf_pkg::cmd_t c);
        mfbf_pkg::result_t res;
        int n;
        longint total;
        res = '0;
        case (c.opcode)
            mfbf_pkg::OP_CLEAR:
            begin
                foreach (capacity[i])
                begin
                    capacity[i] = 0;
                end
            end
            mfbf_pkg::OP_WRITE:
            begin
                capacity[c.from_node * NODES + c.to_node] = c.edge_capacity;
            end
            mfbf_pkg::OP_RUN:
            begin
                n = active_count();
                if (c.source_node == c.sink_node)
                begin
                    res.same_node_error = 1'b1;
                end
                else if (c.source_node < n && c.sink_node < n)
                begin
                    total = max_flow_value(n, c.source_node, c.sink_node);
                    if (total > mfbf_pkg::TOTAL_MAX)
                    begin
                        total = mfbf_pkg::TOTAL_MAX;
                    end
                    res.total_flow = total[21:0];
                end
                expected_results.push_back(res);
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        took <= rst_n && start && !busy;
        if (rst_n && start && !busy)
        begin
            predict(cmd);
        end
    end

    always @(posedge clk)
    begin
        mfbf_pkg::result_t exp_res;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual %h", $time, result);
                errors <= errors + 1;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (exp_res.total_flow !== result.total_flow
                    || exp_res.same_node_error !== result.same_node_error)
                begin
                    $display("%0t: total_flow expected %0d actual %0d, error expected %b actual %b",
                             $time, exp_res.total_flow, result.total_flow,
                             exp_res.same_node_error, result.same_node_error);
                    errors <= errors + 1;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        logic next_start;
        mfbf_pkg::cmd_t next_cmd;
        next_start = start;
        next_cmd = cmd;
        if (rst_n && (!start || took))
        begin
            next_start = 1'b0;
            next_cmd = mfbf_pkg::cmd_t'($urandom);
            if (gap_cycles > 0)
            begin
                gap_cycles <= gap_cycles - 1;
            end
            else if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                gap_cycles <= $urandom_range(1, 16);
            end
            else if (pending_cmds.size() > 0)
            begin
                next_cmd = pending_cmds.pop_front();
                next_start = 1'b1;
            end
        end
        start <= next_start;
        cmd <= next_cmd;
    end

    function automatic mfbf_pkg::cmd_t make_cmd(logic [1:0] op, int a, int b, int capv);
        mfbf_pkg::cmd_t c;
        c = mfbf_pkg::cmd_t'({$urandom, $urandom});
        c.opcode = op;
        if (op == mfbf_pkg::OP_WRITE)
        begin
            c.from_node = 6'(a);
            c.to_node = 6'(b);
            c.edge_capacity = 16'(capv);
        end
        if (op == mfbf_pkg::OP_RUN)
        begin
            c.source_node = 6'(a);
            c.sink_node = 6'(b);
        end
        return c;
    endfunction

    function automatic int pick_node(int n);
        if ($urandom_range(0, 9) == 0)
        begin
            return $urandom_range(0, NODES - 1);
        end
        return $urandom_range(0, n - 1);
    endfunction

    function automatic int pick_capacity();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 65535;
            2, 3: return $urandom_range(0, 65535);
            default: return $urandom_range(1, 20);
        endcase
    endfunction

    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0 || busy);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_node_count(logic [6:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        node_count_reg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_wdata <= 7'($urandom);
    endtask

    task automatic random_phase(int count);
        int n;
        int made;
        int sel;
        int a;
        n = active_count();
        made = 0;
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_CLEAR, 0, 0, 0));
        while (made < count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 2)
            begin
                pending_cmds.push_back(make_cmd(mfbf_pkg::OP_CLEAR, 0, 0, 0));
            end
            else if (sel < 4)
            begin
                pending_cmds.push_back(make_cmd(2'd3, 0, 0, 0));
                continue;
            end
            else if (sel < 88)
            begin
                pending_cmds.push_back(make_cmd(mfbf_pkg::OP_WRITE, pick_node(n), pick_node(n),
                                                pick_capacity()));
            end
            else if (sel < 90)
            begin
                a = pick_node(n);
                pending_cmds.push_back(make_cmd(mfbf_pkg::OP_RUN, a, a, 0));
            end
            else
            begin
                pending_cmds.push_back(make_cmd(mfbf_pkg::OP_RUN, pick_node(n), pick_node(n), 0));
            end
            made++;
        end
    endtask

    initial
    begin
        logic [6:0] settings[] = '{7'd5, 7'd0, 7'd2, 7'd127, 7'd3, 7'd8, 7'd1, 7'd12,
                                   7'd65, 7'd6, 7'd16, 7'd4, 7'd64, 7'd10};
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        took = 1'b0;
        gap_cycles = 0;
        quiet_tail = 1'b0;
        errors = 0;
        cycles = 0;
        node_count_reg = 7'(mfbf_pkg::NODE_COUNT_RESET);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_CLEAR, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_RUN, 0, 63, 0));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_WRITE, 0, 63, 65535));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_WRITE, 63, 0, 0));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_RUN, 0, 63, 0));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_RUN, 63, 0, 0));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_RUN, 7, 7, 0));
        pending_cmds.push_back(make_cmd(2'd3, 1, 2, 3));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_WRITE, 0, 1, 40000));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_WRITE, 1, 63, 30000));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_WRITE, 0, 2, 5));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_WRITE, 2, 1, 65535));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_RUN, 0, 63, 0));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_RUN, 0, 1, 0));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_CLEAR, 0, 0, 0));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_RUN, 0, 63, 0));
        write_node_count(7'd2);
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_WRITE, 0, 1, 65535));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_WRITE, 0, 5, 100));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_RUN, 0, 1, 0));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_RUN, 0, 5, 0));
        pending_cmds.push_back(make_cmd(mfbf_pkg::OP_RUN, 63, 63, 0));

        foreach (settings[i])
        begin
            write_node_count(settings[i]);
            if (i == settings.size() - 1)
            begin
                quiet_tail = 1'b1;
            end
            random_phase(active_count() > 16 ? 60 : 130);
        end

        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
